// ===== hw/rtl/assert_macros.svh =====
// assertion macros, included by the checker top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define MIS_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define MIS_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/mis_pkg.sv =====
// shared types, constants and sizing functions for the independent set checker
package mis_pkg;

    // sizing
    localparam int MAX_VERTICES_DEF = 256;
    localparam int WORD_BITS        = 64;

    // input mode codes
    localparam logic MODE_EDGE   = 1'b0;
    localparam logic MODE_MEMBER = 1'b1;

    // verdict codes
    localparam logic [1:0] VERDICT_DEPENDENT   = 2'd0;
    localparam logic [1:0] VERDICT_NOT_MAXIMAL = 2'd1;
    localparam logic [1:0] VERDICT_MAXIMAL     = 2'd2;

    // control from the sequencer to the set bitmaps
    typedef struct packed {
        logic upd;
        logic set_member;
        logic scan;
        logic clear;
    } map_ctrl_t;

    // status from the set bitmaps
    typedef struct packed {
        logic independent;
        logic uncovered;
    } map_stat_t;

    // 64-bit words per adjacency row
    function automatic int row_words(input int maxv);
        return (maxv + WORD_BITS - 1) / WORD_BITS;
    endfunction

    // bits of a word index within a row, at least one
    function automatic int word_index_bits(input int maxv);
        return (row_words(maxv) > 1) ? $clog2(row_words(maxv)) : 1;
    endfunction

endpackage

// ===== hw/rtl/mis_adj_mem.sv =====
// adjacency matrix memory with a clearing pass after reset
module mis_adj_mem #(
    parameter int MAX_VERTICES = mis_pkg::MAX_VERTICES_DEF
) (
    input  logic                                                clk,
    input  logic                                                rst_n,
    input  logic                                                rd_en,
    input  logic [$clog2(MAX_VERTICES)-1:0]                     rd_row,
    input  logic [mis_pkg::word_index_bits(MAX_VERTICES)-1:0]   rd_word,
    output logic [mis_pkg::WORD_BITS-1:0]                       rd_data,
    input  logic                                                wr_en,
    input  logic [$clog2(MAX_VERTICES)-1:0]                     wr_row,
    input  logic [mis_pkg::word_index_bits(MAX_VERTICES)-1:0]   wr_word,
    input  logic [mis_pkg::WORD_BITS-1:0]                       wr_data,
    output logic                                                clear_busy
);

    localparam int VBITS = $clog2(MAX_VERTICES);
    localparam int WBITS = mis_pkg::word_index_bits(MAX_VERTICES);
    localparam int ABITS = VBITS + WBITS;
    localparam int DEPTH = 1 << ABITS;

    logic [mis_pkg::WORD_BITS-1:0] mem [DEPTH];
    logic [mis_pkg::WORD_BITS-1:0] rd_data_reg;
    logic [ABITS-1:0]              clr_addr_reg;
    logic [ABITS-1:0]              clr_addr_next;
    logic                          busy_reg;
    logic                          busy_next;
    logic                          mem_we;
    logic [ABITS-1:0]              mem_waddr;
    logic [mis_pkg::WORD_BITS-1:0] mem_wdata;

    // clearing sweep, one word a cycle
    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        busy_next     = busy_reg;
        if (busy_reg)
        begin
            clr_addr_next = clr_addr_reg + ABITS'(1);
            if (clr_addr_reg == '1)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            busy_reg     <= 1'b1;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            busy_reg     <= busy_next;
        end
    end

    // write port shared between the sweep and the sequencer
    always_comb
    begin
        mem_we    = busy_reg | wr_en;
        mem_waddr = busy_reg ? clr_addr_reg : {wr_row, wr_word};
        mem_wdata = busy_reg ? '0 : wr_data;
    end

    // synchronous write and registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[{rd_row, rd_word}];
        end
    end

    assign rd_data    = rd_data_reg;
    assign clear_busy = busy_reg;

endmodule

// ===== hw/rtl/mis_set_maps.sv =====
// membership and coverage bitmaps, independence flag and maximality scan
module mis_set_maps #(
    parameter int MAX_VERTICES = mis_pkg::MAX_VERTICES_DEF
) (
    input  logic                                                clk,
    input  logic                                                rst_n,
    input  mis_pkg::map_ctrl_t                                  ctrl,
    input  logic [mis_pkg::word_index_bits(MAX_VERTICES)-1:0]   word,
    input  logic [mis_pkg::WORD_BITS-1:0]                       row_data,
    input  logic [mis_pkg::word_index_bits(MAX_VERTICES)-1:0]   member_word,
    input  logic [5:0]                                          member_bit,
    input  logic [7:0]                                          top,
    output mis_pkg::map_stat_t                                  stat
);

    localparam int WBITS = mis_pkg::word_index_bits(MAX_VERTICES);
    localparam int WORDS = 1 << WBITS;

    logic [mis_pkg::WORD_BITS-1:0] member_reg  [WORDS];
    logic [mis_pkg::WORD_BITS-1:0] covered_reg [WORDS];
    logic                          indep_reg;
    logic                          indep_next;
    logic                          uncov_reg;
    logic                          uncov_next;
    logic [mis_pkg::WORD_BITS-1:0] scan_mask;
    logic [mis_pkg::WORD_BITS-1:0] open_bits;

    // vertices 1..top that fall into the scanned word
    always_comb
    begin
        logic [WBITS+5:0] bit_idx;
        bit_idx   = '0;
        scan_mask = '0;
        for (int j = 0; j < mis_pkg::WORD_BITS; j++)
        begin
            bit_idx      = {word, 6'(j)};
            scan_mask[j] = (bit_idx != '0) && (32'(bit_idx) <= 32'(top));
        end
    end

    // neither member nor covered
    assign open_bits = ~(member_reg[word] | covered_reg[word]) & scan_mask;

    // flag updates
    always_comb
    begin
        indep_next = indep_reg;
        uncov_next = uncov_reg;
        if (ctrl.clear)
        begin
            indep_next = 1'b1;
            uncov_next = 1'b0;
        end
        else
        begin
            if (ctrl.upd && ((row_data & member_reg[word]) != '0))
            begin
                indep_next = 1'b0;
            end
            if (ctrl.scan && (open_bits != '0))
            begin
                uncov_next = 1'b1;
            end
        end
    end

    // bitmap registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < WORDS; w++)
            begin
                member_reg[w]  <= '0;
                covered_reg[w] <= '0;
            end
            indep_reg <= 1'b1;
            uncov_reg <= 1'b0;
        end
        else
        begin
            indep_reg <= indep_next;
            uncov_reg <= uncov_next;
            if (ctrl.clear)
            begin
                for (int w = 0; w < WORDS; w++)
                begin
                    member_reg[w]  <= '0;
                    covered_reg[w] <= '0;
                end
            end
            else
            begin
                if (ctrl.upd)
                begin
                    covered_reg[word] <= covered_reg[word] | row_data;
                end
                if (ctrl.set_member)
                begin
                    member_reg[member_word][member_bit] <= 1'b1;
                end
            end
        end
    end

    assign stat.independent = indep_reg;
    assign stat.uncovered   = uncov_reg;

endmodule

// ===== hw/rtl/maximal_independent_set_check_core.sv =====
// top level of the maximal independent set checker
//
// Input channel (in_valid/in_ready) carries edge items (mode 0) and query
// members (mode 1); the output channel (out_valid/out_ready) carries one
// verdict per member marked last. vertex_count is written through cfg_we/cfg_wdata;
// the user must do so only while the block is idle, which the block itself does not enforce.
// An edge item does two read-modify-writes of the adjacency memory, one per
// direction, through its separate read and write ports.
// A query member reads one adjacency row a word per cycle to update coverage.
// A last member then scans the coverage words (S_SCAN) and loads the verdict
// into the output register (S_DONE), waiting there while the slot is full.
// After reset the adjacency memory is swept clear over its whole depth, one
// word per cycle; in_ready stays low meanwhile.
// A verdict waits in the output register while the receiver stalls; items
// are still accepted, and only the next verdict waits for the slot to free.
`include "assert_macros.svh"

module maximal_independent_set_check_core #(
    parameter int MAX_VERTICES = mis_pkg::MAX_VERTICES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       mode,
    input  logic [7:0] vertex_a,
    input  logic [7:0] vertex_b,
    input  logic       last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] verdict
);

    localparam int VBITS     = $clog2(MAX_VERTICES);
    localparam int WBITS     = mis_pkg::word_index_bits(MAX_VERTICES);
    localparam int ROW_WORDS = mis_pkg::row_words(MAX_VERTICES);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_E_WR1 = 3'd2;
    localparam logic [2:0] S_E_RD2 = 3'd3;
    localparam logic [2:0] S_E_WR2 = 3'd4;
    localparam logic [2:0] S_Q_ROW = 3'd5;
    localparam logic [2:0] S_SCAN  = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0]                    state_reg;
    logic [2:0]                    state_next;
    logic [7:0]                    vcount_reg;
    logic [7:0]                    a_reg;
    logic [7:0]                    b_reg;
    logic                          last_reg;
    logic [WBITS-1:0]              w_reg;
    logic [WBITS-1:0]              w_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [1:0]                    verdict_reg;
    logic                          load;
    logic                          accept;
    logic                          clear_busy;
    logic                          mem_rd_en;
    logic [VBITS-1:0]              mem_rd_row;
    logic [WBITS-1:0]              mem_rd_word;
    logic [mis_pkg::WORD_BITS-1:0] mem_rd_data;
    logic                          mem_wr_en;
    logic [VBITS-1:0]              mem_wr_row;
    logic [WBITS-1:0]              mem_wr_word;
    logic [mis_pkg::WORD_BITS-1:0] mem_wr_data;
    logic [31:0]                   in_a_ext;
    logic [31:0]                   in_b_ext;
    logic [31:0]                   a_ext;
    logic [31:0]                   b_ext;
    logic                          in_a_ok;
    logic                          in_b_ok;
    logic [7:0]                    top;
    mis_pkg::map_ctrl_t            map_ctrl;
    mis_pkg::map_stat_t            map_stat;

    // vertex count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= 8'd255;
        end
        else if (cfg_we)
        begin
            vcount_reg <= cfg_wdata;
        end
    end

    // highest vertex scanned for coverage
    assign top = (32'(vcount_reg) > 32'(MAX_VERTICES - 1)) ? 8'(MAX_VERTICES - 1) : vcount_reg;

    // vertex decoding
    assign in_a_ext = 32'(vertex_a);
    assign in_b_ext = 32'(vertex_b);
    assign a_ext    = 32'(a_reg);
    assign b_ext    = 32'(b_reg);
    assign in_a_ok  = in_a_ext < 32'(MAX_VERTICES);
    assign in_b_ok  = in_b_ext < 32'(MAX_VERTICES);

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        w_next      = w_reg;
        mem_rd_en   = 1'b0;
        mem_rd_row  = a_ext[VBITS-1:0];
        mem_rd_word = w_reg;
        mem_wr_en   = 1'b0;
        mem_wr_row  = a_ext[VBITS-1:0];
        mem_wr_word = b_ext[6 +: WBITS];
        mem_wr_data = mem_rd_data | (64'd1 << b_reg[5:0]);
        map_ctrl    = '0;
        load        = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                if (!clear_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (mode == mis_pkg::MODE_EDGE)
                    begin
                        if (in_a_ok && in_b_ok)
                        begin
                            mem_rd_en   = 1'b1;
                            mem_rd_row  = in_a_ext[VBITS-1:0];
                            mem_rd_word = in_b_ext[6 +: WBITS];
                            state_next  = S_E_WR1;
                        end
                    end
                    else if (in_a_ok)
                    begin
                        mem_rd_en   = 1'b1;
                        mem_rd_row  = in_a_ext[VBITS-1:0];
                        mem_rd_word = '0;
                        w_next      = '0;
                        state_next  = S_Q_ROW;
                    end
                    else if (last)
                    begin
                        w_next     = '0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_E_WR1:
            begin
                mem_wr_en  = 1'b1;
                state_next = S_E_RD2;
            end
            S_E_RD2:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_row  = b_ext[VBITS-1:0];
                mem_rd_word = a_ext[6 +: WBITS];
                state_next  = S_E_WR2;
            end
            S_E_WR2:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_row  = b_ext[VBITS-1:0];
                mem_wr_word = a_ext[6 +: WBITS];
                mem_wr_data = mem_rd_data | (64'd1 << a_reg[5:0]);
                state_next  = S_IDLE;
            end
            S_Q_ROW:
            begin
                map_ctrl.upd = 1'b1;
                if (w_reg == WBITS'(ROW_WORDS - 1))
                begin
                    map_ctrl.set_member = 1'b1;
                    w_next              = '0;
                    state_next          = last_reg ? S_SCAN : S_IDLE;
                end
                else
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_word = w_reg + WBITS'(1);
                    w_next      = w_reg + WBITS'(1);
                end
            end
            S_SCAN:
            begin
                map_ctrl.scan = 1'b1;
                if (w_reg == WBITS'(ROW_WORDS - 1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    w_next = w_reg + WBITS'(1);
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load           = 1'b1;
                    map_ctrl.clear = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output slot
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            w_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            w_reg         <= w_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_reg    <= vertex_a;
            b_reg    <= vertex_b;
            last_reg <= last;
        end
        if (load)
        begin
            if (!map_stat.independent)
            begin
                verdict_reg <= mis_pkg::VERDICT_DEPENDENT;
            end
            else if (map_stat.uncovered)
            begin
                verdict_reg <= mis_pkg::VERDICT_NOT_MAXIMAL;
            end
            else
            begin
                verdict_reg <= mis_pkg::VERDICT_MAXIMAL;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign verdict   = verdict_reg;

    // adjacency memory
    mis_adj_mem #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_adj_mem (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_en      (mem_rd_en),
        .rd_row     (mem_rd_row),
        .rd_word    (mem_rd_word),
        .rd_data    (mem_rd_data),
        .wr_en      (mem_wr_en),
        .wr_row     (mem_wr_row),
        .wr_word    (mem_wr_word),
        .wr_data    (mem_wr_data),
        .clear_busy (clear_busy)
    );

    // set bitmaps
    mis_set_maps #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_set_maps (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (map_ctrl),
        .word        (w_reg),
        .row_data    (mem_rd_data),
        .member_word (a_ext[6 +: WBITS]),
        .member_bit  (a_reg[5:0]),
        .top         (top),
        .stat        (map_stat)
    );

    // assertions
    `MIS_ASSERT(a_no_accept_in_sweep, in_ready |-> !clear_busy, "item accepted during clearing sweep")
    `MIS_ASSERT(a_no_write_in_sweep, mem_wr_en |-> !clear_busy, "adjacency write during clearing sweep")
    `MIS_ASSERT(a_load_slot_free, load |-> (!out_valid_reg || out_ready), "verdict overwrote a pending one")
    `MIS_ASSERT(a_row_read_before, (state_reg == S_Q_ROW) |-> $past(mem_rd_en), "row word used without a read")
    `MIS_ASSERT(a_word_in_range, ((state_reg == S_Q_ROW) || (state_reg == S_SCAN)) |-> (w_reg <= WBITS'(ROW_WORDS - 1)), "word index past row end")

endmodule
